// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(name, cond, msg) \
  `ASSERT_PROP(name, !(cond), msg)

`endif

// File: rtl/core/rsd_pkg.sv
// Shared types and constants of the RGBE scanline RLE decoder.
package rsd_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MIN_WIDTH     = 8;
  localparam int NUM_PLANES    = 3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_TOTAL = 1'd1;

  localparam logic [11:0] LINE_WIDTH_RST = 12'd8;
  localparam logic [15:0] LINE_TOTAL_RST = 16'd1;

  localparam logic [7:0] HDR_MAGIC     = 8'd2;
  localparam logic [2:0] HDR_FLAG_STEP = 3'd2;
  localparam logic [2:0] HDR_LAST_STEP = 3'd3;
  localparam logic [2:0] HDR_BYTES     = 3'd4;
  localparam logic [7:0] RUN_BIAS      = 8'd128;
  localparam logic [1:0] CHAN_EXPO     = 2'd3;

  typedef enum logic [1:0] {
    STEP_HOLD,
    STEP_PAIR,
    STEP_SINGLE,
    STEP_ERR
  } step_kind_e;

  typedef enum logic [1:0] {
    MARK_INSIDE,
    MARK_LINE_END,
    MARK_IMAGE_END
  } mark_e;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_BAD_HEADER,
    STATUS_OVERRUN
  } status_e;

  // lane 0 red, lane 1 green, lane 2 blue
  typedef logic [NUM_PLANES-1:0][7:0] rsd_rgb_t;

  typedef struct packed {
    step_kind_e kind;
    logic [7:0] expo;
    logic       last;
    mark_e      mark;
    status_e    status;
  } rsd_step_t;

  typedef struct packed {
    logic [7:0] red_a;
    logic [7:0] green_a;
    logic [7:0] blue_a;
    logic [7:0] expo_a;
    logic [7:0] red_b;
    logic [7:0] green_b;
    logic [7:0] blue_b;
    logic [7:0] expo_b;
    logic [1:0] pixel_count;
    logic       run_last;
    mark_e      place_mark;
    status_e    status;
  } rsd_result_t;

endpackage

// File: rtl/core/rsd_line_store.sv
// Line store: one RGB word per pixel, byte-lane write, registered read.
module rsd_line_store #(
  parameter int MAX_WIDTH = rsd_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [1:0]        wr_lane_i,
  input  logic [7:0]        wr_data_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     addr_i,
  output rsd_pkg::rsd_rgb_t rd_data_o
);
  import rsd_pkg::*;

  rsd_rgb_t mem [MAX_WIDTH];
  rsd_rgb_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i][wr_lane_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/rsd_parser.sv
// Byte parser: header check, run/literal counts and per-pixel plane sequencing.
module rsd_parser #(
  parameter int MAX_WIDTH = rsd_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(MAX_WIDTH),
  localparam int PW = $clog2(MAX_WIDTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [PW-1:0]      line_width_i,
  input  logic [15:0]        line_total_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         byte_in_i,
  input  logic               take_i,
  output logic               step_valid_o,
  output rsd_pkg::rsd_step_t step_o,
  output logic               wr_en_o,
  output logic [1:0]         wr_lane_o,
  output logic [7:0]         wr_data_o,
  output logic               rd_en_o,
  output logic [AW-1:0]      addr_o
);
  import rsd_pkg::*;

  localparam int SW = ((PW > 8) ? PW : 8) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_ERROR
  } state_e;

  state_e      state_q;
  logic [2:0]  hdr_q;
  logic [1:0]  chan_q;
  logic [PW-1:0] pos_q;
  logic [7:0]  pend_q;
  logic        run_q;
  logic [15:0] lines_q;
  logic        err_q;
  logic [7:0]  val_q;
  logic [7:0]  cnt_q;
  status_e     code_q;

  logic          accept;
  logic          is_expo;
  logic          do_write;
  logic [PW-1:0] pos_inc;
  logic [PW-1:0] pos_fin;
  logic          at_end;
  logic          step_go;
  logic          done;
  logic          lines_last;
  logic          last_emit;
  logic          hdr_bad;
  logic [7:0]    count_n;
  logic          overrun;

  assign accept   = in_valid_i && in_ready_o;
  assign is_expo  = (chan_q == CHAN_EXPO);
  assign do_write = (pos_q < line_width_i);
  assign pos_inc  = pos_q + PW'(1);
  assign at_end   = (pos_inc >= line_width_i);
  assign step_go  = (state_q == ST_EXPAND) && (!is_expo || !do_write || take_i);
  assign done     = !do_write || (cnt_q == 8'd1) || at_end;
  assign pos_fin  = do_write ? pos_inc : pos_q;

  assign lines_last = ({1'b0, lines_q} + 17'd1) >= {1'b0, line_total_i};
  // an odd-pixel emit is the last result of the byte when the next step only holds
  assign last_emit  = (cnt_q == 8'd1) ||
                      ((cnt_q == 8'd2) &&
                       (({1'b0, pos_q} + (PW+1)'(2)) < {1'b0, line_width_i}));

  assign hdr_bad = ((hdr_q < HDR_FLAG_STEP) && (byte_in_i != HDR_MAGIC)) ||
                   ((hdr_q == HDR_FLAG_STEP) && byte_in_i[7]);
  assign count_n = (byte_in_i > RUN_BIAS) ? (byte_in_i - RUN_BIAS) : byte_in_i;
  assign overrun = (SW'(pos_q) + SW'(count_n)) > SW'(line_width_i);

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    step_o        = '0;
    step_o.kind   = STEP_ERR;
    step_o.status = code_q;
    step_o.last   = 1'b1;
    step_valid_o  = 1'b0;
    if (state_q == ST_EXPAND) begin
      step_valid_o = is_expo && do_write && take_i;
      step_o.status = STATUS_OK;
      step_o.expo   = val_q;
      step_o.last   = last_emit;
      if (pos_q[0]) begin
        step_o.kind = STEP_PAIR;
      end else if (at_end) begin
        step_o.kind = STEP_SINGLE;
      end else begin
        step_o.kind = STEP_HOLD;
      end
      if (at_end) begin
        step_o.mark = lines_last ? MARK_IMAGE_END : MARK_LINE_END;
      end
    end else if (state_q == ST_ERROR) begin
      step_valid_o = take_i;
    end
  end

  assign wr_en_o   = (state_q == ST_EXPAND) && !is_expo && do_write;
  assign rd_en_o   = (state_q == ST_EXPAND) && is_expo && do_write && take_i;
  assign wr_lane_o = chan_q;
  assign wr_data_o = val_q;
  assign addr_o    = pos_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hdr_q   <= '0;
      chan_q  <= '0;
      pos_q   <= '0;
      pend_q  <= '0;
      run_q   <= 1'b0;
      lines_q <= '0;
      err_q   <= 1'b0;
      val_q   <= '0;
      cnt_q   <= '0;
      code_q  <= STATUS_OK;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && !err_q && (lines_q < line_total_i)) begin
            if (hdr_q != HDR_BYTES) begin
              if (hdr_bad) begin
                code_q  <= STATUS_BAD_HEADER;
                state_q <= ST_ERROR;
              end else begin
                hdr_q <= hdr_q + 3'd1;
                if (hdr_q == HDR_LAST_STEP) begin
                  chan_q <= '0;
                  pos_q  <= '0;
                  pend_q <= '0;
                  run_q  <= 1'b0;
                end
              end
            end else if (run_q) begin
              val_q   <= byte_in_i;
              cnt_q   <= pend_q;
              run_q   <= 1'b0;
              pend_q  <= '0;
              state_q <= ST_EXPAND;
            end else if (pend_q != 8'd0) begin
              val_q   <= byte_in_i;
              cnt_q   <= 8'd1;
              pend_q  <= pend_q - 8'd1;
              state_q <= ST_EXPAND;
            end else if (count_n != 8'd0) begin
              if (overrun) begin
                code_q  <= STATUS_OVERRUN;
                state_q <= ST_ERROR;
              end else begin
                pend_q <= count_n;
                run_q  <= (byte_in_i > RUN_BIAS);
              end
            end
          end
        end
        ST_EXPAND: begin
          if (step_go) begin
            // advance one pixel; close the plane or the line at its end
            pos_q <= pos_fin;
            cnt_q <= cnt_q - 8'd1;
            if (done) begin
              state_q <= ST_IDLE;
              if (pos_fin >= line_width_i) begin
                pos_q <= '0;
                if (!is_expo) begin
                  chan_q <= chan_q + 2'd1;
                end else begin
                  lines_q <= lines_q + 16'd1;
                  hdr_q   <= '0;
                  chan_q  <= '0;
                  pend_q  <= '0;
                  run_q   <= 1'b0;
                end
              end
            end
          end
        end
        ST_ERROR: begin
          if (take_i) begin
            err_q   <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/rsd_pair_emit.sv
// Pair emitter: joins store reads with exponents and holds the result register.
module rsd_pair_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_valid_i,
  input  rsd_pkg::rsd_step_t   step_i,
  input  rsd_pkg::rsd_rgb_t    rd_data_i,
  output logic                 take_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rsd_pkg::rsd_result_t result_o
);
  import rsd_pkg::*;

  logic        s1_valid_q;
  rsd_step_t   s1_q;
  rsd_rgb_t    held_rgb_q;
  logic [7:0]  held_expo_q;
  logic        out_valid_q;
  rsd_result_t res_q;
  rsd_result_t res_d;
  logic        retire;

  assign retire = s1_valid_q &&
                  ((s1_q.kind == STEP_HOLD) || !out_valid_q || out_ready_i);
  assign take_o = !s1_valid_q || retire;

  always_comb begin
    res_d             = '0;
    res_d.run_last    = s1_q.last;
    res_d.place_mark  = s1_q.mark;
    res_d.status      = s1_q.status;
    case (s1_q.kind)
      STEP_PAIR: begin
        res_d.red_a       = held_rgb_q[0];
        res_d.green_a     = held_rgb_q[1];
        res_d.blue_a      = held_rgb_q[2];
        res_d.expo_a      = held_expo_q;
        res_d.red_b       = rd_data_i[0];
        res_d.green_b     = rd_data_i[1];
        res_d.blue_b      = rd_data_i[2];
        res_d.expo_b      = s1_q.expo;
        res_d.pixel_count = 2'd2;
      end
      STEP_SINGLE: begin
        res_d.red_a       = rd_data_i[0];
        res_d.green_a     = rd_data_i[1];
        res_d.blue_a      = rd_data_i[2];
        res_d.expo_a      = s1_q.expo;
        res_d.pixel_count = 2'd1;
      end
      STEP_ERR: begin
        res_d.run_last   = 1'b1;
        res_d.place_mark = MARK_INSIDE;
      end
      default: begin
        res_d.pixel_count = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (step_valid_i) begin
        s1_valid_q <= 1'b1;
      end else if (retire) begin
        s1_valid_q <= 1'b0;
      end
      if (retire && (s1_q.kind != STEP_HOLD)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_valid_i) begin
      s1_q <= step_i;
    end
    if (retire) begin
      if (s1_q.kind == STEP_HOLD) begin
        held_rgb_q  <= rd_data_i;
        held_expo_q <= s1_q.expo;
      end else begin
        res_q <= res_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

// File: rtl/core/rgbe_scanline_rle_decoder.sv
// Top level of the RGBE scanline RLE decoder: config registers and datapath.
//
// Usage: feed the encoded pixel bytes of an adaptive-RLE RGBE image on the
// byte_in channel (valid/ready), one item per byte. Each scanline starts with
// a four-byte header, then four planes (red, green, blue, exponent) of runs
// and literals. Results come out on the output channel as pixel pairs (a
// single pixel when a line ends on an odd pixel), or as one error item with
// status set, after which the block drops every byte until reset.
// Write line_width and line_total on the config port while idle only.
// A header or count byte is taken in the idle state; a data byte is accepted
// and then expanded over every pixel it covers (one for a literal, n for a
// run of n) before the next byte is taken, as the single-port line store and
// the plane sequencer step one pixel a cycle while the emitter takes steps.
// A result is registered in the store read, then in the output register. When
// the receiver stalls, the exponent sequencer holds and input is
// back-pressured; a finished result waits in the output register while the
// next one is prepared. Reset clears all control state and restores
// line_width 8, line_total 1; the line store is not cleared, every entry is
// written before it is read.
`include "assert_macros.svh"

module rgbe_scanline_rle_decoder #(
  parameter int MAX_WIDTH = rsd_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rsd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rsd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    byte_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    red_a_o,
  output logic [7:0]                    green_a_o,
  output logic [7:0]                    blue_a_o,
  output logic [7:0]                    expo_a_o,
  output logic [7:0]                    red_b_o,
  output logic [7:0]                    green_b_o,
  output logic [7:0]                    blue_b_o,
  output logic [7:0]                    expo_b_o,
  output logic [1:0]                    pixel_count_o,
  output logic                          run_last_o,
  output logic [1:0]                    place_mark_o,
  output logic [1:0]                    status_o
);
  import rsd_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int PW = $clog2(MAX_WIDTH + 1);

  logic [11:0]   line_width_q;
  logic [15:0]   line_total_q;
  logic [15:0]   lw_ext;
  logic [PW-1:0] eff_width;

  rsd_step_t   step;
  logic        step_valid;
  logic        take;
  logic        wr_en;
  logic [1:0]  wr_lane;
  logic [7:0]  wr_data;
  logic        rd_en;
  logic [AW-1:0] addr;
  rsd_rgb_t    rd_data;
  rsd_result_t result;

  // config registers: plain write, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RST;
      line_total_q <= LINE_TOTAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LINE_WIDTH: line_width_q <= cfg_data_i[11:0];
        CFG_LINE_TOTAL: line_total_q <= cfg_data_i[15:0];
        default: begin
          line_total_q <= line_total_q;
        end
      endcase
    end
  end

  // saturate the width into the range the store supports
  assign lw_ext = 16'(line_width_q);
  always_comb begin
    if (lw_ext < 16'(MIN_WIDTH)) begin
      eff_width = PW'(MIN_WIDTH);
    end else if (lw_ext > 16'(MAX_WIDTH)) begin
      eff_width = PW'(MAX_WIDTH);
    end else begin
      eff_width = PW'(lw_ext);
    end
  end

  rsd_parser #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .line_width_i(eff_width),
    .line_total_i(line_total_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .byte_in_i   (byte_in_i),
    .take_i      (take),
    .step_valid_o(step_valid),
    .step_o      (step),
    .wr_en_o     (wr_en),
    .wr_lane_o   (wr_lane),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .addr_o      (addr)
  );

  rsd_line_store #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_lane_i(wr_lane),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .addr_i   (addr),
    .rd_data_o(rd_data)
  );

  rsd_pair_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_valid_i(step_valid),
    .step_i      (step),
    .rd_data_i   (rd_data),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign red_a_o       = result.red_a;
  assign green_a_o     = result.green_a;
  assign blue_a_o      = result.blue_a;
  assign expo_a_o      = result.expo_a;
  assign red_b_o       = result.red_b;
  assign green_b_o     = result.green_b;
  assign blue_b_o      = result.blue_b;
  assign expo_b_o      = result.expo_b;
  assign pixel_count_o = result.pixel_count;
  assign run_last_o    = result.run_last;
  assign place_mark_o  = result.place_mark;
  assign status_o      = result.status;

  // store planes are written and read in disjoint phases of a line
  `ASSERT_NEVER(a_store_rw_overlap, wr_en && rd_en, "line store written and read together")
  // a step is only issued when the emitter has room for it
  `ASSERT_PROP(a_issue_room, step_valid |-> take, "step issued while emitter is full")
  // an item with no pixels is always an error item
  `ASSERT_PROP(a_empty_is_error, out_valid_o && pixel_count_o == 2'd0 |-> status_o != STATUS_OK, "empty item without error status")
  // nothing follows a delivered error item
  `ASSERT_PROP(a_error_final, out_valid_o && out_ready_i && status_o != STATUS_OK |=> !out_valid_o, "item after error")

endmodule
